// ===== hw/rtl/typed_event_queue_unit_defines.svh =====
// Assertion macros used by the typed event queue unit.
`ifndef TYPED_EVENT_QUEUE_UNIT_DEFINES_SVH
`define TYPED_EVENT_QUEUE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/teq_pkg.sv =====
`default_nettype none
package teq_pkg;
  localparam int QUEUE_DEPTH  = 256;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > 6) ? CNT_W : 6;
  localparam int ENTRY_W = 16 + 32 + PAYLOAD_BITS;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_PEEK   = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;
  localparam logic [1:0] MODE_FLUSH  = 2'd3;

  typedef struct packed {
    logic [15:0]             etype;
    logic [31:0]             etime;
    logic [PAYLOAD_BITS-1:0] epay;
  } entry_t;
endpackage
`default_nettype wire

// ===== hw/rtl/teq_ram.sv =====
`default_nettype none
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/typed_event_queue_unit.sv =====
// Typed event queue: arrival-ordered store of (type, time, payload) entries.
// Input channel (in_valid/in_ready) takes one request: append, peek range,
// get range or flush range. Result channel (out_valid/out_ready) returns the
// event results of a peek or get, then one status result with out_last = 1.
// A request is taken only while the block is idle. Peek, flush and
// count-only scan every held entry at one entry per cycle unless a stalled
// receiver holds the scan. A get that delivers events first counts matches,
// then scans again to deliver and compact. The single-port-read entry memory
// sets the rate: one read and one compacting write per cycle when not stalled.
// Reset clears occupancy, state and out_valid; the memory is not cleared, and only
// occupied entries are ever read.
// A stalled receiver holds the scan on the entry whose event waits for the
// output register; nothing is lost and the memory read data holds.
`default_nettype none
`include "typed_event_queue_unit_defines.svh"
module typed_event_queue_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_mode,
  input  wire logic [15:0]                     in_type,
  input  wire logic [31:0]                     in_time,
  input  wire logic [63:0]                     in_payload,
  input  wire logic [15:0]                     in_min_type,
  input  wire logic [15:0]                     in_max_type,
  input  wire logic                            in_want_events,
  input  wire logic [5:0]                      in_max_events,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [15:0]                     out_type,
  output logic      [31:0]                     out_time,
  output logic      [63:0]                     out_payload,
  output logic                                 out_event_valid,
  output logic      [8:0]                      out_matched_count,
  output logic                                 out_queue_full,
  output logic      [8:0]                      out_entries_held,
  output logic                                 out_last
);
  import teq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CNT  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [15:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic             want_r, want_nxt;
  logic [5:0]       limit_r, limit_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt, fin_r, fin_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, w_r, w_nxt, used_r, used_nxt;
  logic             full_r, full_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       otype_r, otype_nxt;
  logic [31:0]       otime_r, otime_nxt;
  logic [63:0]       opay_r, opay_nxt;
  logic              oev_r, oev_nxt, olast_r, olast_nxt, ofull_r, ofull_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt, oheld_r, oheld_nxt;

  // memory port
  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  entry_t             ent, app_ent;

  logic             match, under_limit, compacting, remove, deliver, counted;
  logic             out_free, stall, last_pos;
  logic [CNT_W-1:0] cnt_inc, take;
  logic             scanning, scan_we, scan_dlv;

  teq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ent         = entry_t'(rdata);
  assign match       = (ent.etype >= lo_r) && (ent.etype <= hi_r);
  assign under_limit = CMP_W'(used_r) < CMP_W'(limit_r);
  assign compacting  = (mode_r == MODE_GET) || (mode_r == MODE_FLUSH);
  assign deliver     = want_r && ((mode_r == MODE_PEEK) || (mode_r == MODE_GET))
                       && match && under_limit;
  assign remove      = ((mode_r == MODE_FLUSH) && match) ||
                       ((mode_r == MODE_GET) && deliver);
  assign counted     = remove || deliver || ((mode_r != MODE_FLUSH) && !want_r && match);
  assign out_free    = !out_valid_r || out_ready;
  assign stall       = deliver && !out_free;
  assign last_pos    = (i_r + CNT_W'(1)) == occ_r;
  assign cnt_inc     = used_r + CNT_W'(match);
  assign take        = (CMP_W'(cnt_inc) < CMP_W'(limit_r)) ? cnt_inc : CNT_W'(limit_r);

  assign app_ent.etype = in_type;
  assign app_ent.etime = in_time;
  assign app_ent.epay  = in_payload[PAYLOAD_BITS-1:0];

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;  mode_nxt = mode_r;  lo_nxt = lo_r;  hi_nxt = hi_r;
    want_nxt = want_r;  limit_nxt = limit_r;  occ_nxt = occ_r;  fin_nxt = fin_r;
    i_nxt = i_r;  w_nxt = w_r;  used_nxt = used_r;  full_nxt = full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    otype_nxt = otype_r;  otime_nxt = otime_r;  opay_nxt = opay_r;
    oev_nxt = oev_r;  olast_nxt = olast_r;  ofull_nxt = ofull_r;
    ocnt_nxt = ocnt_r;  oheld_nxt = oheld_r;
    we = 1'b0;  waddr = w_r[IDX_W-1:0];  wdata = rdata;
    re = 1'b0;  raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          lo_nxt    = in_min_type;
          hi_nxt    = in_max_type;
          want_nxt  = in_want_events;
          limit_nxt = in_max_events;
          i_nxt     = '0;
          w_nxt     = '0;
          used_nxt  = '0;
          full_nxt  = 1'b0;
          fin_nxt   = occ_r;
          if (in_mode == MODE_APPEND) begin
            state_nxt = S_DONE;
            if (occ_r < CNT_W'(QUEUE_DEPTH)) begin
              we       = 1'b1;
              waddr    = occ_r[IDX_W-1:0];
              wdata    = app_ent;
              occ_nxt  = occ_r + CNT_W'(1);
              used_nxt = CNT_W'(1);
            end else begin
              full_nxt = 1'b1;
            end
          end else if (occ_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            re = 1'b1;
            // get with delivery needs final occupancy before the first event
            state_nxt = ((in_mode == MODE_GET) && in_want_events) ? S_CNT : S_SCAN;
          end
        end
      end
      S_CNT: begin
        re = 1'b1;
        if (last_pos) begin
          fin_nxt   = occ_r - take;
          used_nxt  = '0;
          i_nxt     = '0;
          raddr     = '0;
          state_nxt = S_SCAN;
        end else begin
          used_nxt = cnt_inc;
          i_nxt    = i_r + CNT_W'(1);
          raddr    = i_nxt[IDX_W-1:0];
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (deliver) begin
            out_valid_nxt = 1'b1;
            otype_nxt = ent.etype;
            otime_nxt = ent.etime;
            opay_nxt  = 64'(ent.epay);
            oev_nxt   = 1'b1;
            olast_nxt = 1'b0;
            ofull_nxt = 1'b0;
            ocnt_nxt  = '0;
            oheld_nxt = fin_r;
          end
          // slide survivors down over removed entries
          if (compacting && !remove) begin
            we    = 1'b1;
            waddr = w_r[IDX_W-1:0];
            wdata = rdata;
            w_nxt = w_r + CNT_W'(1);
          end
          used_nxt = used_r + CNT_W'(counted);
          if (last_pos) begin
            if (compacting) begin
              occ_nxt = w_nxt;
            end
            state_nxt = S_DONE;
          end else begin
            i_nxt = i_r + CNT_W'(1);
            re    = 1'b1;
            raddr = i_nxt[IDX_W-1:0];
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          otype_nxt = '0;
          otime_nxt = '0;
          opay_nxt  = '0;
          oev_nxt   = 1'b0;
          olast_nxt = 1'b1;
          ofull_nxt = full_r;
          ocnt_nxt  = used_r;
          oheld_nxt = occ_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;   lo_r   <= lo_nxt;   hi_r    <= hi_nxt;
    want_r  <= want_nxt;   limit_r <= limit_nxt; fin_r <= fin_nxt;
    i_r     <= i_nxt;      w_r    <= w_nxt;    used_r  <= used_nxt;
    full_r  <= full_nxt;
    otype_r <= otype_nxt;  otime_r <= otime_nxt; opay_r <= opay_nxt;
    oev_r   <= oev_nxt;    olast_r <= olast_nxt; ofull_r <= ofull_nxt;
    ocnt_r  <= ocnt_nxt;   oheld_r <= oheld_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_type          = otype_r;
  assign out_time          = otime_r;
  assign out_payload       = opay_r;
  assign out_event_valid   = oev_r;
  assign out_matched_count = 9'(ocnt_r);
  assign out_queue_full    = ofull_r;
  assign out_entries_held  = 9'(oheld_r);
  assign out_last          = olast_r;

  assign scanning = (state_r == S_SCAN) || (state_r == S_CNT);
  assign scan_we  = (state_r == S_SCAN) && we;
  assign scan_dlv = (state_r == S_SCAN) && deliver;

  `TEQ_ASSERT(a_occ_bound, clk, rst_n, occ_r <= CNT_W'(QUEUE_DEPTH), "occupancy overflow")
  `TEQ_ASSERT(a_scan_in_range, clk, rst_n, scanning |-> (i_r < occ_r), "scan past occupancy")
  `TEQ_ASSERT(a_compact_behind, clk, rst_n, scan_we |-> (w_r <= i_r), "write ahead of read")
  `TEQ_ASSERT(a_limit, clk, rst_n, scan_dlv |-> (CMP_W'(used_r) < CMP_W'(limit_r)), "over limit")
endmodule
`default_nettype wire

// ===== bench/teq_checker.sv =====
`default_nettype none
module teq_checker
  import teq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_type,
  input  wire logic [31:0] in_time,
  input  wire logic [63:0] in_payload,
  input  wire logic [15:0] in_min_type,
  input  wire logic [15:0] in_max_type,
  input  wire logic        in_want_events,
  input  wire logic [5:0]  in_max_events,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [15:0] out_type,
  input  wire logic [31:0] out_time,
  input  wire logic [63:0] out_payload,
  input  wire logic        out_event_valid,
  input  wire logic [8:0]  out_matched_count,
  input  wire logic        out_queue_full,
  input  wire logic [8:0]  out_entries_held,
  input  wire logic        out_last,
  output int               err_count,
  output int               results_owed
);

  typedef struct {
    logic [15:0] etype;
    logic [31:0] etime;
    logic [63:0] epay;
    logic        ev;
    logic [8:0]  cnt;
    logic        full;
    logic [8:0]  held;
    logic        last;
  } event_result_t;

  logic [15:0] type_mem [QUEUE_DEPTH];
  logic [31:0] time_mem [QUEUE_DEPTH];
  logic [63:0] pay_mem  [QUEUE_DEPTH];
  int unsigned head = 0;
  int unsigned fill = 0;
  event_result_t owed_q [$];

  initial err_count = 0;
  initial results_owed = 0;

  function automatic int unsigned slot_of(int unsigned pos);
    return (head + pos) % QUEUE_DEPTH;
  endfunction

  // drop the entry at pos, shift the tail down to keep order
  function automatic void drop_entry(int unsigned pos);
    int unsigned d;
    int unsigned s;
    if (pos == 0) begin
      head = (head + 1) % QUEUE_DEPTH;
    end else begin
      for (int unsigned k = pos + 1; k < fill; k++) begin
        d = slot_of(k - 1);
        s = slot_of(k);
        type_mem[d] = type_mem[s];
        time_mem[d] = time_mem[s];
        pay_mem[d]  = pay_mem[s];
      end
    end
    fill--;
  endfunction

  function automatic event_result_t status_result(int unsigned cnt, logic full);
    event_result_t r;
    r.etype = '0;
    r.etime = '0;
    r.epay = '0;
    r.ev = 1'b0;
    r.cnt = cnt[8:0];
    r.full = full;
    r.held = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void predict_queue_op();
    event_result_t evs [$];
    event_result_t r;
    int unsigned i;
    int unsigned used;
    int unsigned s;
    logic full;
    i = 0;
    used = 0;
    if (in_mode == MODE_APPEND) begin
      full = (fill >= QUEUE_DEPTH);
      if (!full) begin
        s = slot_of(fill);
        type_mem[s] = in_type;
        time_mem[s] = in_time;
        pay_mem[s]  = in_payload;
        fill++;
      end
      r = status_result(full ? 0 : 1, full);
    end else if (in_mode == MODE_FLUSH) begin
      while (i < fill) begin
        s = slot_of(i);
        if (type_mem[s] >= in_min_type && type_mem[s] <= in_max_type) begin
          drop_entry(i);
          used++;
        end else begin
          i++;
        end
      end
      r = status_result(used, 1'b0);
    end else begin
      while (i < fill && (!in_want_events || used < in_max_events)) begin
        s = slot_of(i);
        if (type_mem[s] < in_min_type || type_mem[s] > in_max_type) begin
          i++;
        end else if (in_want_events) begin
          r = status_result(0, 1'b0);
          r.etype = type_mem[s];
          r.etime = time_mem[s];
          r.epay = pay_mem[s];
          r.ev = 1'b1;
          r.last = 1'b0;
          evs.push_back(r);
          used++;
          if (in_mode == MODE_GET) drop_entry(i);
          else i++;
        end else begin
          used++;
          i++;
        end
      end
      r = status_result(used, 1'b0);
    end
    // occupancy is final only now
    foreach (evs[k]) begin
      evs[k].held = fill[8:0];
      owed_q.push_back(evs[k]);
    end
    r.held = fill[8:0];
    owed_q.push_back(r);
  endfunction

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    event_result_t e;
    if (in_valid && in_ready) predict_queue_op();
    if (out_valid && out_ready) begin
      if (owed_q.size() == 0) begin
        $error("unexpected result: type %0h last %0b", out_type, out_last);
        err_count++;
      end else begin
        e = owed_q.pop_front();
        check_field("out_type", 64'(e.etype), 64'(out_type));
        check_field("out_time", 64'(e.etime), 64'(out_time));
        check_field("out_payload", e.epay, out_payload);
        check_field("out_event_valid", 64'(e.ev), 64'(out_event_valid));
        check_field("out_matched_count", 64'(e.cnt), 64'(out_matched_count));
        check_field("out_queue_full", 64'(e.full), 64'(out_queue_full));
        check_field("out_entries_held", 64'(e.held), 64'(out_entries_held));
        check_field("out_last", 64'(e.last), 64'(out_last));
      end
    end
    results_owed = owed_q.size();
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
  import teq_pkg::*;

  localparam int STALL_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_APPEND;
  logic [15:0] in_type = '0;
  logic [31:0] in_time = '0;
  logic [63:0] in_payload = '0;
  logic [15:0] in_min_type = '0;
  logic [15:0] in_max_type = '0;
  logic        in_want_events = 1'b0;
  logic [5:0]  in_max_events = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_type;
  logic [31:0] out_time;
  logic [63:0] out_payload;
  logic        out_event_valid;
  logic [8:0]  out_matched_count;
  logic        out_queue_full;
  logic [8:0]  out_entries_held;
  logic        out_last;

  int err_count;
  int results_owed;
  int quiet_cycles = 0;
  // high during the stretch where neither side idles
  logic no_idle = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typed_event_queue_unit dut (.*);

  teq_checker chk (.*);

  // receiver: stalls at random, 38 percent of the time, never during the no-idle stretch
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 38);
  end

  // watchdog: abort when no request and no result moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // drive one request and hold it until it is taken
  task automatic send_request(logic [1:0] mode, logic [15:0] etype, logic [31:0] etime,
                              logic [63:0] epay, logic [15:0] lo, logic [15:0] hi,
                              logic want, logic [5:0] limit);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_type        <= etype;
    in_time        <= etime;
    in_payload     <= epay;
    in_min_type    <= lo;
    in_max_type    <= hi;
    in_want_events <= want;
    in_max_events  <= limit;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // small types mostly, so ranges actually hit; now and then any type
  function automatic logic [15:0] rand_type();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
  endfunction

  task automatic append_random();
    send_request(MODE_APPEND, rand_type(), $urandom, rand_word(), 16'($urandom),
                 16'($urandom), 1'($urandom), 6'($urandom));
  endtask

  task automatic range_random(logic [1:0] mode);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = 16'($urandom_range(7));
    hi = lo + 16'($urandom_range(3));
    case ($urandom_range(9))
      0: begin
        lo = 16'h0000;
        hi = 16'hffff;
      end
      1: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      2: hi = lo - 16'd1;
      default: ;
    endcase
    send_request(mode, rand_type(), $urandom, rand_word(), lo, hi,
                 $urandom_range(5) != 0, 6'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode on an empty queue
    send_request(MODE_PEEK, '0, '0, '0, 16'h0000, 16'hffff, 1'b1, 6'd63);
    send_request(MODE_GET, '0, '0, '0, 16'h0000, 16'hffff, 1'b1, 6'd63);
    send_request(MODE_FLUSH, '0, '0, '0, 16'h0000, 16'hffff, 1'b0, 6'd0);
    // field extremes on append; append ignores range and limit
    send_request(MODE_APPEND, 16'h0000, 32'h0, 64'h0, 16'hffff, 16'h0, 1'b1, 6'd63);
    send_request(MODE_APPEND, 16'hffff, 32'hffffffff, '1, 16'h0, 16'hffff, 1'b0, 6'd0);
    send_request(MODE_APPEND, 16'd3, 32'h12345678, 64'h0123456789abcdef, '0, '0, 1'b0, '0);
    send_request(MODE_APPEND, 16'd5, 32'h00000001, 64'h8000000000000001, '0, '0, 1'b0, '0);
    send_request(MODE_APPEND, 16'd3, 32'h80000000, 64'h7fffffffffffffff, '0, '0, 1'b0, '0);
    send_request(MODE_APPEND, 16'd4, 32'h55aa55aa, 64'haaaa5555aaaa5555, '0, '0, 1'b0, '0);
    // full-range peek, then an empty range, then a zero limit
    send_request(MODE_PEEK, '0, '0, '0, 16'h0000, 16'hffff, 1'b1, 6'd63);
    send_request(MODE_PEEK, '0, '0, '0, 16'd5, 16'd3, 1'b1, 6'd63);
    send_request(MODE_GET, '0, '0, '0, 16'd0, 16'hffff, 1'b1, 6'd0);
    // count only: peek and get count every match, remove nothing
    send_request(MODE_PEEK, '0, '0, '0, 16'd3, 16'd5, 1'b0, 6'd1);
    send_request(MODE_GET, '0, '0, '0, 16'd3, 16'd5, 1'b0, 6'd0);
    // get one from the middle type range, then all of type 3
    send_request(MODE_GET, '0, '0, '0, 16'd4, 16'd5, 1'b1, 6'd1);
    send_request(MODE_GET, '0, '0, '0, 16'd3, 16'd3, 1'b1, 6'd63);
    send_request(MODE_FLUSH, '0, '0, '0, 16'd9, 16'd2, 1'b1, 6'd5);
    send_request(MODE_FLUSH, '0, '0, '0, 16'hffff, 16'hffff, 1'b0, 6'd0);
    send_request(MODE_PEEK, '0, '0, '0, 16'h0000, 16'hffff, 1'b1, 6'd63);
    send_request(MODE_FLUSH, '0, '0, '0, 16'h0000, 16'hffff, 1'b0, 6'd0);

    // random mix
    for (int n = 0; n < 90; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) append_random();
      else if (pick < 70) range_random(MODE_PEEK);
      else if (pick < 90) range_random(MODE_GET);
      else range_random(MODE_FLUSH);
    end

    // hold off until every result is in, then fill past full with no idling
    wait_drained();
    no_idle <= 1'b1;
    for (int n = 0; n < 262; n++) append_random();
    range_random(MODE_PEEK);
    range_random(MODE_GET);
    send_request(MODE_PEEK, '0, '0, '0, 16'h0000, 16'hffff, 1'b1, 6'd63);
    send_request(MODE_GET, '0, '0, '0, 16'h0000, 16'hffff, 1'b1, 6'd63);
    append_random();
    no_idle <= 1'b0;
    range_random(MODE_FLUSH);
    send_request(MODE_FLUSH, '0, '0, '0, 16'h0000, 16'hffff, 1'b0, 6'd0);

    for (int n = 0; n < 30; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) append_random();
      else if (pick < 70) range_random(MODE_PEEK);
      else if (pick < 90) range_random(MODE_GET);
      else range_random(MODE_FLUSH);
    end

    // drain, then let the last scan settle
    wait_drained();
    repeat (600) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
